// ===== hdl/synchronous_average_capture_defines.svh =====
// Assertion macros shared by the synchronous average capture RTL
`ifndef SYNCHRONOUS_AVERAGE_CAPTURE_DEFINES_SVH
`define SYNCHRONOUS_AVERAGE_CAPTURE_DEFINES_SVH

// same-cycle implication, checked on clk, held off during reset
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, held off during reset
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sac_pkg.sv =====
// Shared types and constants for the synchronous average capture block
package sac_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int ORDER_W    = 5;
  localparam int REPEAT_W   = 4;
  localparam int SKIP_W     = 20;
  localparam int COUNT_W    = 20;
  localparam int INDEX_W    = 16;
  localparam int CMD_W      = 2;
  localparam int DIV_DIGITS = 4;

  localparam int LENGTH_ORDER_RST = 16;

  localparam logic [ORDER_W-1:0]  MIN_ORDER        = 5'd4;
  localparam logic [REPEAT_W-1:0] MAX_REPEATS      = 4'd8;
  localparam logic [REPEAT_W-1:0] REPEAT_TOTAL_RST = 4'd1;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TOTAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_SAMPLES = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_RESULT
  } sac_state_t;

  typedef struct packed {
    logic mem_rd;
    logic keep_old;
    logic acc_wr;
    logic div_start;
  } sac_lane_ctrl_t;

endpackage

// ===== hdl/sac_in_if.sv =====
// Input item channel: command, lane samples and read index
interface sac_in_if import sac_pkg::*; #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;
  logic [INDEX_W-1:0]            read_index;

  modport source (output valid, cmd, sample_0, sample_1, read_index, input ready);
  modport sink   (input valid, cmd, sample_0, sample_1, read_index, output ready);
endinterface

// ===== hdl/sac_out_if.sv =====
// Result item channel: status, captured count and lane averages
interface sac_out_if import sac_pkg::*; #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          complete;
  logic [COUNT_W-1:0]            captured_count;
  logic signed [SAMPLE_BITS-1:0] average_0;
  logic signed [SAMPLE_BITS-1:0] average_1;

  modport source (output valid, complete, captured_count, average_0, average_1,
                  input ready);
  modport sink   (input valid, complete, captured_count, average_0, average_1,
                  output ready);
endinterface

// ===== hdl/sac_div.sv =====
// Iterative signed divider by a small repeat count, several quotient bits per cycle
module sac_div import sac_pkg::*; #(
  parameter int IN_W  = 27,
  parameter int OUT_W = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [IN_W-1:0]  dividend,
  input  logic [REPEAT_W-1:0]     divisor,
  output logic                    done,
  output logic signed [OUT_W-1:0] quotient
);

  localparam int STEPS = (IN_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int PAD_W = STEPS * DIV_DIGITS;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = REPEAT_W - 1;

  logic [PAD_W-1:0]    quo_r;
  logic [REM_W-1:0]    rem_r;
  logic [REPEAT_W-1:0] div_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [IN_W-1:0]     mag;
  logic [PAD_W-1:0]    quo_nxt;
  logic [REM_W-1:0]    rem_nxt;
  logic [REM_W:0]      trial;
  logic [PAD_W:0]      q_ext;
  logic [PAD_W:0]      q_signed;

  assign mag = dividend[IN_W-1] ? IN_W'(-dividend) : IN_W'(dividend);

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      trial   = {rem_nxt, quo_nxt[PAD_W-1]};
      quo_nxt = {quo_nxt[PAD_W-2:0], 1'b0};
      if (trial >= div_r) begin
        rem_nxt    = REM_W'(trial - div_r);
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PAD_W'(mag);
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[IN_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign q_ext    = {1'b0, quo_r};
  assign q_signed = neg_r ? -q_ext : q_ext;
  assign quotient = q_signed[OUT_W-1:0];
  assign done     = done_r;

endmodule

// ===== hdl/sac_lane.sv =====
// One capture lane: sum memory with read-modify-write accumulate and average divider
module sac_lane import sac_pkg::*; #(
  parameter int ADDR_W      = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sac_lane_ctrl_t                ctrl,
  input  logic [ADDR_W-1:0]             addr,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [REPEAT_W-1:0]           divisor,
  output logic                          div_done,
  output logic signed [SAMPLE_BITS-1:0] average
);

  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int DEPTH = 1 << ADDR_W;

  logic signed [SUM_W-1:0]       mem [DEPTH];
  logic signed [SUM_W-1:0]       rd_data_r;
  logic [ADDR_W-1:0]             addr_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          keep_r;

  logic signed [SUM_W-1:0]       old_sum;
  logic signed [SUM_W-1:0]       sum_nxt;

  assign old_sum = keep_r ? rd_data_r : '0;
  assign sum_nxt = old_sum + SUM_W'(sample_r);

  always_ff @(posedge clk) begin
    if (ctrl.mem_rd) begin
      rd_data_r <= mem[addr];
      addr_r    <= addr;
      sample_r  <= sample;
      keep_r    <= ctrl.keep_old;
    end
    if (ctrl.acc_wr) begin
      mem[addr_r] <= sum_nxt;
    end
  end

  sac_div #(
    .IN_W  (SUM_W),
    .OUT_W (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (old_sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (average)
  );

endmodule

// ===== hdl/synchronous_average_capture.sv =====
// Top level: session control, capture lanes and result merge register
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      cmd, sample_0, sample_1, read_index
//   out_ch   out  valid / ready      complete, captured_count, average_0, average_1
//   cfg_*    in   cfg_we (no stall)  cfg_index, cfg_data
//
// Start, unused commands, a read before any start and a dropped or ignored sample
// go straight to the result state, a captured sample first through the accumulate
// state (registered memory read, then write back). A read in a session passes through
// the load and divide states; the divider retires 4 quotient bits per cycle.
// Sum memories need no clear: entries count as zero until written this session.
// A result waiting on out_ch holds the next item only once it reaches the merge stage.
`include "synchronous_average_capture_defines.svh"

module synchronous_average_capture import sac_pkg::*; #(
  parameter int MAX_LENGTH_LOG2 = 16,
  parameter int CHANNELS        = 2,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sac_in_if.sink                in_ch,
  sac_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W      = MAX_LENGTH_LOG2;
  localparam int CNT_W       = (ADDR_W + REPEAT_W > COUNT_W) ? ADDR_W + REPEAT_W : COUNT_W;
  localparam int IDX_EXT_W   = ADDR_W + INDEX_W;
  localparam int ORDER_RST_I = (LENGTH_ORDER_RST > MAX_LENGTH_LOG2) ?
                               MAX_LENGTH_LOG2 : LENGTH_ORDER_RST;
  localparam logic [ORDER_W-1:0] MAX_ORDER = ORDER_W'(MAX_LENGTH_LOG2);
  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(ORDER_RST_I);

  logic [ORDER_W-1:0]  length_order_r, length_order_nxt;
  logic [REPEAT_W-1:0] repeat_total_r, repeat_total_nxt;
  logic [SKIP_W-1:0]   latency_r, latency_nxt;

  sac_state_t          state_r, state_nxt;
  logic [ORDER_W-1:0]  frame_order_r, frame_order_nxt;
  logic [REPEAT_W-1:0] repeats_target_r, repeats_target_nxt;
  logic [REPEAT_W-1:0] repeats_done_r, repeats_done_nxt;
  logic [SKIP_W-1:0]   skip_left_r, skip_left_nxt;
  logic [ADDR_W-1:0]   write_index_r, write_index_nxt;
  logic                avg_on_r, avg_on_nxt;

  logic                          out_valid_r;
  logic                          out_complete_r;
  logic [COUNT_W-1:0]            out_count_r;
  logic signed [SAMPLE_BITS-1:0] out_avg0_r;
  logic signed [SAMPLE_BITS-1:0] out_avg1_r;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic [ADDR_W-1:0]   frame_mask;
  logic [ADDR_W-1:0]   wr_idx;
  logic [IDX_EXT_W-1:0] rd_ext;
  logic [ADDR_W-1:0]   rd_idx;
  logic                capture_ok;
  logic                keep_rd;
  logic [ORDER_W-1:0]  order_clamped;
  logic [REPEAT_W-1:0] target_clamped;
  logic [CNT_W-1:0]    count_wide;

  sac_lane_ctrl_t      lane_ctrl;
  logic [ADDR_W-1:0]   lane_addr;
  logic signed [SAMPLE_BITS-1:0] lane_sample [2];
  logic signed [SAMPLE_BITS-1:0] lane_avg [2];
  logic                lane_done [2];
  logic                div_done;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign frame_mask = (ADDR_W'(1) << frame_order_r) - ADDR_W'(1);
  assign wr_idx     = write_index_r & frame_mask;
  assign rd_ext     = {{ADDR_W{1'b0}}, in_ch.read_index};
  assign rd_idx     = rd_ext[ADDR_W-1:0] & frame_mask;
  assign capture_ok = (skip_left_r == '0) && (repeats_done_r < repeats_target_r);
  assign keep_rd    = (repeats_done_r != '0) || (rd_idx < write_index_r);

  always_comb begin
    if (length_order_r < MIN_ORDER) begin
      order_clamped = MIN_ORDER;
    end else if (length_order_r > MAX_ORDER) begin
      order_clamped = MAX_ORDER;
    end else begin
      order_clamped = length_order_r;
    end
    if (repeat_total_r == '0) begin
      target_clamped = REPEAT_W'(1);
    end else if (repeat_total_r > MAX_REPEATS) begin
      target_clamped = MAX_REPEATS;
    end else begin
      target_clamped = repeat_total_r;
    end
  end

  // configuration registers
  always_comb begin
    length_order_nxt = length_order_r;
    repeat_total_nxt = repeat_total_r;
    latency_nxt      = latency_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH_ORDER:    length_order_nxt = cfg_data[ORDER_W-1:0];
        CFG_REPEAT_TOTAL:    repeat_total_nxt = cfg_data[REPEAT_W-1:0];
        CFG_LATENCY_SAMPLES: latency_nxt      = cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // session state
  always_comb begin
    frame_order_nxt    = frame_order_r;
    repeats_target_nxt = repeats_target_r;
    repeats_done_nxt   = repeats_done_r;
    skip_left_nxt      = skip_left_r;
    write_index_nxt    = write_index_r;
    avg_on_nxt         = avg_on_r;
    if (in_fire) begin
      avg_on_nxt = 1'b0;
      case (in_ch.cmd)
        CMD_START: begin
          frame_order_nxt    = order_clamped;
          repeats_target_nxt = target_clamped;
          skip_left_nxt      = latency_r;
          repeats_done_nxt   = '0;
          write_index_nxt    = '0;
        end
        CMD_SAMPLE: begin
          if (skip_left_r != '0) begin
            skip_left_nxt = skip_left_r - 1'b1;
          end else if (repeats_done_r < repeats_target_r) begin
            if (wr_idx == frame_mask) begin
              write_index_nxt  = '0;
              repeats_done_nxt = repeats_done_r + 1'b1;
            end else begin
              write_index_nxt = wr_idx + 1'b1;
            end
          end
        end
        CMD_READ: avg_on_nxt = (repeats_target_r != '0);
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            CMD_SAMPLE: state_nxt = capture_ok ? ST_ACC : ST_RESULT;
            CMD_READ:   state_nxt = (repeats_target_r != '0) ? ST_LOAD : ST_RESULT;
            default:    state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_ACC:    state_nxt = ST_RESULT;
      ST_LOAD:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = div_done ? ST_RESULT : ST_DIV;
      ST_RESULT: state_nxt = out_free ? ST_IDLE : ST_RESULT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready         = 1'b0;
    lane_ctrl           = '0;
    lane_addr           = wr_idx;
    out_load            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.cmd == CMD_READ) begin
          lane_addr          = rd_idx;
          lane_ctrl.keep_old = keep_rd;
          lane_ctrl.mem_rd   = in_fire && (repeats_target_r != '0);
        end else begin
          lane_ctrl.keep_old = (repeats_done_r != '0);
          lane_ctrl.mem_rd   = in_fire && (in_ch.cmd == CMD_SAMPLE) && capture_ok;
        end
      end
      ST_ACC:    lane_ctrl.acc_wr    = 1'b1;
      ST_LOAD:   lane_ctrl.div_start = 1'b1;
      ST_RESULT: out_load            = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_order_r   <= ORDER_W'(LENGTH_ORDER_RST);
      repeat_total_r   <= REPEAT_TOTAL_RST;
      latency_r        <= '0;
      state_r          <= ST_IDLE;
      frame_order_r    <= ORDER_RST;
      repeats_target_r <= '0;
      repeats_done_r   <= '0;
      skip_left_r      <= '0;
      write_index_r    <= '0;
      avg_on_r         <= 1'b0;
    end else begin
      length_order_r   <= length_order_nxt;
      repeat_total_r   <= repeat_total_nxt;
      latency_r        <= latency_nxt;
      state_r          <= state_nxt;
      frame_order_r    <= frame_order_nxt;
      repeats_target_r <= repeats_target_nxt;
      repeats_done_r   <= repeats_done_nxt;
      skip_left_r      <= skip_left_nxt;
      write_index_r    <= write_index_nxt;
      avg_on_r         <= avg_on_nxt;
    end
  end

  assign lane_sample[0] = in_ch.sample_0;
  assign lane_sample[1] = in_ch.sample_1;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      sac_lane #(
        .ADDR_W      (ADDR_W),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .addr     (lane_addr),
        .sample   (lane_sample[g]),
        .divisor  (repeats_target_r),
        .div_done (lane_done[g]),
        .average  (lane_avg[g])
      );
    end else begin : g_off
      assign lane_done[g] = 1'b0;
      assign lane_avg[g]  = '0;
    end
  end

  assign div_done = lane_done[0];

  // merge lanes and status into the result register
  assign count_wide = (CNT_W'(repeats_done_r) << frame_order_r) + CNT_W'(write_index_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_complete_r <= (repeats_done_r >= repeats_target_r);
      out_count_r    <= count_wide[COUNT_W-1:0];
      out_avg0_r     <= avg_on_r ? lane_avg[0] : '0;
      out_avg1_r     <= avg_on_r ? lane_avg[1] : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.complete       = out_complete_r;
  assign out_ch.captured_count = out_count_r;
  assign out_ch.average_0      = out_avg0_r;
  assign out_ch.average_1      = out_avg1_r;

  `SAC_ASSERT_NOW(a_done_bound, 1'b1, repeats_done_r <= repeats_target_r, "repeat count overran target")
  `SAC_ASSERT_NOW(a_index_in_frame, 1'b1, (write_index_r & ~frame_mask) == '0, "write index outside frame")
  `SAC_ASSERT_NOW(a_div_done_state, div_done, state_r == ST_DIV, "divider finished outside wait")
  `SAC_ASSERT_NEXT(a_skip_drop, in_fire && (in_ch.cmd == CMD_SAMPLE) && (skip_left_r != '0), (skip_left_r == $past(skip_left_r) - 1'b1) && (state_r == ST_RESULT), "dropped item did not count down")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the synchronous average capture block
module testbench import sac_pkg::*;;

  localparam int CLK_PERIOD     = 12;
  localparam int LENGTH_LOG2    = 16;
  localparam int LANES          = 2;
  localparam int LANE_BITS      = 24;
  localparam int ITEM_TARGET    = 1350;
  localparam int CALM_AFTER     = 1150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_CYCLES = 800000;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam logic signed [LANE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [LANE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

  typedef struct packed {
    logic                        complete;
    logic [COUNT_W-1:0]          captured_count;
    logic signed [LANE_BITS-1:0] average_0;
    logic signed [LANE_BITS-1:0] average_1;
  } capture_report_t;

  class capture_tracker;
    logic [ORDER_W-1:0]  order_reg;
    logic [REPEAT_W-1:0] repeats_reg;
    logic [SKIP_W-1:0]   skip_reg;
    longint              lane0_sum[int];
    longint              lane1_sum[int];
    int                  skip_left;
    int                  repeats_done;
    int                  write_index;
    int                  repeats_target;
    int                  frame_order;
    capture_report_t     due_reports[$];
    int                  mismatches;
    int                  results_checked;

    function new();
      order_reg       = ORDER_W'(LENGTH_ORDER_RST);
      repeats_reg     = REPEAT_TOTAL_RST;
      skip_reg        = '0;
      skip_left       = 0;
      repeats_done    = 0;
      write_index     = 0;
      repeats_target  = 0;
      frame_order     = LENGTH_ORDER_RST;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LENGTH_ORDER:    order_reg = data[ORDER_W-1:0];
        CFG_REPEAT_TOTAL:    repeats_reg = data[REPEAT_W-1:0];
        CFG_LATENCY_SAMPLES: skip_reg = data[SKIP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void take_item(logic [CMD_W-1:0] cmd, logic signed [LANE_BITS-1:0] s0,
                            logic signed [LANE_BITS-1:0] s1, logic [INDEX_W-1:0] ri);
      capture_report_t rep;
      int              frame_len;
      int              slot;
      int              span;
      longint          sum0;
      longint          sum1;
      longint          quot0;
      longint          quot1;
      rep = '0;
      if (cmd == CMD_START) begin
        lane0_sum.delete();
        lane1_sum.delete();
        if (order_reg < MIN_ORDER) frame_order = MIN_ORDER;
        else if (order_reg > LENGTH_LOG2) frame_order = LENGTH_LOG2;
        else frame_order = order_reg;
        if (repeats_reg == 0) repeats_target = 1;
        else if (repeats_reg > MAX_REPEATS) repeats_target = MAX_REPEATS;
        else repeats_target = repeats_reg;
        skip_left    = skip_reg;
        repeats_done = 0;
        write_index  = 0;
      end
      frame_len = 1 << frame_order;
      if (cmd == CMD_SAMPLE) begin
        if (skip_left > 0) begin
          skip_left--;
        end else if (repeats_done < repeats_target) begin
          slot = write_index & (frame_len - 1);
          lane0_sum[slot] = (lane0_sum.exists(slot) ? lane0_sum[slot] : 0) + longint'(s0);
          if (LANES > 1)
            lane1_sum[slot] = (lane1_sum.exists(slot) ? lane1_sum[slot] : 0) + longint'(s1);
          slot++;
          if (slot >= frame_len) begin
            repeats_done++;
            slot = 0;
          end
          write_index = slot;
        end
      end else if (cmd == CMD_READ && repeats_target != 0) begin
        slot  = int'(ri) & (frame_len - 1);
        sum0  = lane0_sum.exists(slot) ? lane0_sum[slot] : 0;
        sum1  = lane1_sum.exists(slot) ? lane1_sum[slot] : 0;
        quot0 = sum0 / longint'(repeats_target);
        quot1 = sum1 / longint'(repeats_target);
        rep.average_0 = quot0[LANE_BITS-1:0];
        if (LANES > 1) rep.average_1 = quot1[LANE_BITS-1:0];
      end
      span = (repeats_done << frame_order) + write_index;
      rep.complete       = repeats_done >= repeats_target;
      rep.captured_count = span[COUNT_W-1:0];
      due_reports.push_back(rep);
    endfunction

    function void check_result(capture_report_t got);
      capture_report_t want;
      if (due_reports.size() == 0) begin
        $error("captured_count: expected no result, got %0d", got.captured_count);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      results_checked++;
      if (got.complete !== want.complete) begin
        $error("complete: expected %0d, got %0d", want.complete, got.complete);
        mismatches++;
      end
      if (got.captured_count !== want.captured_count) begin
        $error("captured_count: expected %0d, got %0d", want.captured_count,
               got.captured_count);
        mismatches++;
      end
      if (got.average_0 !== want.average_0) begin
        $error("average_0: expected %0d, got %0d", want.average_0, got.average_0);
        mismatches++;
      end
      if (got.average_1 !== want.average_1) begin
        $error("average_1: expected %0d, got %0d", want.average_1, got.average_1);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sac_in_if  #(.SAMPLE_BITS(LANE_BITS)) in_ch ();
  sac_out_if #(.SAMPLE_BITS(LANE_BITS)) out_ch ();

  capture_tracker tracker = new();

  bit calm;
  int items_sent;
  int reads_sent;
  int sessions_run;

  synchronous_average_capture #(
    .MAX_LENGTH_LOG2(LENGTH_LOG2),
    .CHANNELS       (LANES),
    .SAMPLE_BITS    (LANE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [LANE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return LANE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 1) == 0) return INDEX_W'($urandom());
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [LANE_BITS-1:0] s0,
                           input logic signed [LANE_BITS-1:0] s1,
                           input logic [INDEX_W-1:0] ri);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.sample_0   <= s0;
    in_ch.sample_1   <= s1;
    in_ch.read_index <= ri;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_item(cmd, s0, s1, ri);
    items_sent++;
    if (cmd == CMD_READ) reads_sent++;
    calm = items_sent >= CALM_AFTER;
  endtask

  task automatic send_random(input logic [CMD_W-1:0] cmd);
    send_item(cmd, pick_sample(), pick_sample(), pick_index());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [ORDER_W-1:0] ord, input logic [REPEAT_W-1:0] reps,
                                input logic [SKIP_W-1:0] lat);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH_ORDER;
    cfg_data  <= CFG_DATA_W'(ord);
    @(posedge clk);
    tracker.set_reg(CFG_LENGTH_ORDER, CFG_DATA_W'(ord));
    cfg_index <= CFG_REPEAT_TOTAL;
    cfg_data  <= CFG_DATA_W'(reps);
    @(posedge clk);
    tracker.set_reg(CFG_REPEAT_TOTAL, CFG_DATA_W'(reps));
    cfg_index <= CFG_LATENCY_SAMPLES;
    cfg_data  <= CFG_DATA_W'(lat);
    @(posedge clk);
    tracker.set_reg(CFG_LATENCY_SAMPLES, CFG_DATA_W'(lat));
    cfg_we <= 1'b0;
  endtask

  task automatic run_session(input int idx);
    logic [ORDER_W-1:0]  ord;
    logic [REPEAT_W-1:0] reps;
    logic [SKIP_W-1:0]   lat;
    int                  eff_order;
    int                  eff_reps;
    int                  n_samples;
    int                  pick;
    if (idx == 0) begin
      ord  = '1;
      reps = '1;
      lat  = '1;
    end else if (idx == 1) begin
      ord  = ORDER_W'(LENGTH_LOG2);
      reps = MAX_REPEATS;
      lat  = '0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) ord = 5'd4;
      else if (pick < 85) ord = 5'd5;
      else if (pick < 92) ord = 5'd6;
      else if (pick < 96) ord = ORDER_W'($urandom_range(0, 3));
      else ord = ORDER_W'($urandom_range(7, 31));
      pick = $urandom_range(0, 99);
      reps = (pick < 12) ? REPEAT_W'($urandom_range(0, 15)) : REPEAT_W'($urandom_range(1, 8));
      pick = $urandom_range(0, 99);
      if (pick < 70) lat = SKIP_W'($urandom_range(0, 3));
      else if (pick < 95) lat = SKIP_W'($urandom_range(4, 40));
      else lat = SKIP_W'($urandom());
    end
    write_settings(ord, reps, lat);
    // hold the old session open now and then: new settings wait for a start
    if (idx < 2 || $urandom_range(0, 7) != 0) send_random(CMD_START);

    eff_order = (ord < MIN_ORDER) ? MIN_ORDER : ((ord > LENGTH_LOG2) ? LENGTH_LOG2 : ord);
    eff_reps  = (reps == 0) ? 1 : ((reps > MAX_REPEATS) ? MAX_REPEATS : reps);
    n_samples = int'(lat) + (eff_reps << eff_order) + $urandom_range(0, 4);
    if (eff_order <= 6 && n_samples > 560) n_samples = 560;
    if (eff_order > 6 && n_samples > 200) n_samples = 200;

    for (int k = 0; k < n_samples && items_sent < ITEM_TARGET; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) send_random(CMD_READ);
      else if (pick < 17) send_random(CMD_SPARE);
      else if (pick < 18) send_random(CMD_START);
      send_random(CMD_SAMPLE);
    end
    repeat ($urandom_range(3, 10)) send_random(CMD_READ);
    sessions_run++;
  endtask

  initial begin
    int              stall_left;
    capture_report_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.complete       = out_ch.complete;
        got.captured_count = out_ch.captured_count;
        got.average_0      = out_ch.average_0;
        got.average_1      = out_ch.average_1;
        tracker.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int session_no;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_START;
    in_ch.sample_0   <= '0;
    in_ch.sample_1   <= '0;
    in_ch.read_index <= '0;
    calm         = 1'b0;
    items_sent   = 0;
    reads_sent   = 0;
    sessions_run = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle block: complete with zero averages, ignore a stray sample
    send_item(CMD_READ, SAMPLE_MAX, SAMPLE_MIN, '1);
    send_item(CMD_SPARE, SAMPLE_MIN, SAMPLE_MAX, '1);
    send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, '0);

    // clamp low order and zero repeats, drop two samples, fill one frame
    write_settings('0, '0, SKIP_W'(2));
    send_item(CMD_START, '0, '0, '0);
    for (int k = 0; k < 18; k++) begin
      case (k % 4)
        0:       send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, '0);
        1:       send_item(CMD_SAMPLE, SAMPLE_MIN, SAMPLE_MAX, '1);
        2:       send_item(CMD_SAMPLE, -24'sd1, 24'sd1, '0);
        default: send_random(CMD_SAMPLE);
      endcase
    end
    send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, '0);
    send_item(CMD_READ, '0, '0, '1);
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, '1, '1, 16'h8002);

    session_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_session(session_no);
      session_no++;
    end

    drain();
    $display("Sent %0d items (%0d reads) over %0d capture sessions.", items_sent, reads_sent,
             sessions_run);
    $display("Checked %0d results, %0d field mismatches.", tracker.results_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sac_pkg.sv
hdl/sac_in_if.sv
hdl/sac_out_if.sv
hdl/sac_div.sv
hdl/sac_lane.sv
hdl/synchronous_average_capture.sv
verif/testbench.sv
